// ===== rtl/binary_hex_record_loader_defines.svh =====
// Assertion macros used by the record loader top level.
`ifndef BINARY_HEX_RECORD_LOADER_DEFINES_SVH
`define BINARY_HEX_RECORD_LOADER_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that a condition implies another in the same cycle.
`define HRL_ASSERT_IMPLIES(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) \
        (ante) |-> (cons)) else $error("record loader check failed");

// Checks that a condition implies another in the next cycle.
`define HRL_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) \
        (ante) |=> (cons)) else $error("record loader check failed");

`else

`define HRL_ASSERT_IMPLIES(label, clk_sig, rst_sig, ante, cons)
`define HRL_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons)

`endif

`endif

// ===== rtl/hrl_pkg.sv =====
// Shared types and constants of the binary hex record loader.
`default_nettype none

package hrl_pkg;

    // Address and size widths and the reset ROM size.
    localparam int ROM_SIZE_W         = 17;
    localparam int DEFAULT_ADDR_WIDTH = 16;
    localparam logic [ROM_SIZE_W-1:0] RESET_ROM_SIZE = 17'h10000;

    // Record type codes.
    localparam logic [7:0] REC_DATA     = 8'd0;
    localparam logic [7:0] REC_END      = 8'd1;
    localparam logic [7:0] REC_EXT_ADDR = 8'd4;

    // Loader status codes.
    localparam logic [2:0] ST_BUSY   = 3'd0;
    localparam logic [2:0] ST_OK     = 3'd1;
    localparam logic [2:0] ST_SUM    = 3'd2;
    localparam logic [2:0] ST_RANGE  = 3'd3;
    localparam logic [2:0] ST_ENDLEN = 3'd4;
    localparam logic [2:0] ST_EXT    = 3'd5;
    localparam logic [2:0] ST_TYPE   = 3'd6;
    localparam logic [2:0] ST_SHORT  = 3'd7;

    // One input beat: a stream byte and its markers.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
        logic       restart;
    } in_beat_t;

    // One result beat: an optional ROM write and the loader status.
    typedef struct packed {
        logic        write_valid;
        logic [15:0] write_addr;
        logic [7:0]  write_data;
        logic        finished;
        logic [2:0]  status;
    } out_beat_t;

endpackage

`default_nettype wire

// ===== rtl/binary_hex_record_loader.sv =====
// Top level of the binary hex record loader: input register, parser, result register.
`default_nettype none
`include "binary_hex_record_loader_defines.svh"

// The loader takes one byte of a binary hex record stream per beat and returns
// exactly one result beat per input beat, carrying an optional ROM write and
// the current loader status. It sustains one byte per clock cycle while
// out_ready stays high. A byte is held in the input register while the record
// parse runs in the logic behind it, and its result is then loaded into the
// result register, from which it is presented. in_ready follows out_ready
// combinationally through the two registers, so the input register and the
// result register together act as a two-entry buffer. rom_size may be written
// only while no beat is in flight; it takes effect on the next byte parsed.
module binary_hex_record_loader #(
    parameter int ADDR_WIDTH = hrl_pkg::DEFAULT_ADDR_WIDTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire hrl_pkg::in_beat_t              in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output hrl_pkg::out_beat_t                  out_data,
    input  wire logic                           cfg_write_en,
    input  wire logic [hrl_pkg::ROM_SIZE_W-1:0] cfg_write_data
);

    localparam logic [hrl_pkg::ROM_SIZE_W-1:0] ROM_CAP =
        hrl_pkg::ROM_SIZE_W'(1) << ADDR_WIDTH;

    logic                              in_valid_reg, in_valid_next;
    hrl_pkg::in_beat_t                 in_beat_reg;
    logic                              out_valid_reg, out_valid_next;
    hrl_pkg::out_beat_t                out_beat_reg;
    logic [hrl_pkg::ROM_SIZE_W-1:0]    rom_size_reg;
    logic [hrl_pkg::ROM_SIZE_W-1:0]    limit;
    logic                              advance;
    logic                              step;
    hrl_pkg::out_beat_t                result;

    // Handshake and pipeline movement.
    assign advance        = !out_valid_reg || out_ready;
    assign in_ready       = !in_valid_reg || advance;
    assign step           = in_valid_reg && advance;
    assign in_valid_next  = (in_valid && in_ready) || (in_valid_reg && !advance);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    // Effective ROM size is capped by the address space.
    assign limit = (rom_size_reg < ROM_CAP) ? rom_size_reg : ROM_CAP;

    hrl_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .beat   (in_beat_reg),
        .limit  (limit),
        .result (result)
    );

    // Pipeline valid bits and the configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rom_size_reg  <= hrl_pkg::RESET_ROM_SIZE;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                rom_size_reg <= cfg_write_data;
            end
        end
    end

    // Payload registers load only when their stage takes a new beat.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_beat_reg <= in_data;
        end
        if (step)
        begin
            out_beat_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_beat_reg;

    // A ROM write never comes from a loader that has already ended.
    `HRL_ASSERT_IMPLIES(a_write_not_finished, clk, rst_n, out_valid && out_data.write_valid, !out_data.finished)

    // Finished and a non-busy status always travel together.
    `HRL_ASSERT_IMPLIES(a_finished_status, clk, rst_n, out_valid, out_data.finished == (out_data.status != hrl_pkg::ST_BUSY))

    // Beats without a write carry a zero address and zero data.
    `HRL_ASSERT_IMPLIES(a_idle_write_zero, clk, rst_n, out_valid && !out_data.write_valid, out_data.write_addr == 16'd0 && out_data.write_data == 8'd0)

    // A held input beat is still in the input register on the next cycle.
    `HRL_ASSERT_NEXT(a_input_held, clk, rst_n, in_valid_reg && !advance, in_valid_reg)

endmodule

`default_nettype wire

// ===== rtl/hrl_parser.sv =====
// Record parser: holds the parse state and computes one result per byte.
`default_nettype none

module hrl_parser (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              step,
    input  wire hrl_pkg::in_beat_t                 beat,
    input  wire logic [hrl_pkg::ROM_SIZE_W-1:0]    limit,
    output hrl_pkg::out_beat_t                     result
);

    typedef enum logic [2:0] {
        PH_LEN,
        PH_AHI,
        PH_ALO,
        PH_TYPE,
        PH_DATA,
        PH_CHECK
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  record_length_reg, record_length_next;
    logic [15:0] record_addr_reg, record_addr_next;
    logic [7:0]  record_type_reg, record_type_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic        ended_reg, ended_next;
    logic [2:0]  final_status_reg, final_status_next;

    logic [7:0]  sum_with_byte;

    // Next parse state and result for the byte at the head of the pipe.
    always_comb
    begin
        phase_next         = phase_reg;
        record_length_next = record_length_reg;
        record_addr_next   = record_addr_reg;
        record_type_next   = record_type_reg;
        bytes_left_next    = bytes_left_reg;
        running_sum_next   = running_sum_reg;
        ended_next         = ended_reg;
        final_status_next  = final_status_reg;
        result             = '0;

        // A restart clears the parser before the byte is looked at.
        if (beat.restart)
        begin
            phase_next         = PH_LEN;
            record_length_next = '0;
            record_addr_next   = '0;
            record_type_next   = '0;
            bytes_left_next    = '0;
            running_sum_next   = '0;
            ended_next         = 1'b0;
            final_status_next  = hrl_pkg::ST_BUSY;
        end

        sum_with_byte = running_sum_next + beat.byte_value;

        if (!ended_next)
        begin
            case (phase_next)
                PH_LEN:
                begin
                    record_length_next = beat.byte_value;
                    running_sum_next   = beat.byte_value;
                    phase_next         = PH_AHI;
                    if (beat.last_byte)
                    begin
                        ended_next        = 1'b1;
                        final_status_next = hrl_pkg::ST_SHORT;
                    end
                end
                PH_AHI:
                begin
                    record_addr_next = {beat.byte_value, 8'h00};
                    running_sum_next = sum_with_byte;
                    phase_next       = PH_ALO;
                    if (beat.last_byte)
                    begin
                        ended_next        = 1'b1;
                        final_status_next = hrl_pkg::ST_SHORT;
                    end
                end
                PH_ALO:
                begin
                    record_addr_next = {record_addr_next[15:8], beat.byte_value};
                    running_sum_next = sum_with_byte;
                    phase_next       = PH_TYPE;
                    if (beat.last_byte)
                    begin
                        ended_next        = 1'b1;
                        final_status_next = hrl_pkg::ST_SHORT;
                    end
                end
                PH_TYPE:
                begin
                    record_type_next = beat.byte_value;
                    running_sum_next = sum_with_byte;
                    if (beat.last_byte)
                    begin
                        ended_next        = 1'b1;
                        final_status_next = hrl_pkg::ST_SHORT;
                    end
                    else if (beat.byte_value == hrl_pkg::REC_DATA)
                    begin
                        bytes_left_next = record_length_next;
                        phase_next = (record_length_next == 8'd0) ? PH_CHECK : PH_DATA;
                    end
                    else if (beat.byte_value == hrl_pkg::REC_END)
                    begin
                        if (record_length_next != 8'd0)
                        begin
                            ended_next        = 1'b1;
                            final_status_next = hrl_pkg::ST_ENDLEN;
                        end
                        else
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                    else if (beat.byte_value == hrl_pkg::REC_EXT_ADDR)
                    begin
                        ended_next        = 1'b1;
                        final_status_next = hrl_pkg::ST_EXT;
                    end
                    else
                    begin
                        ended_next        = 1'b1;
                        final_status_next = hrl_pkg::ST_TYPE;
                    end
                end
                PH_DATA:
                begin
                    if (beat.last_byte)
                    begin
                        ended_next        = 1'b1;
                        final_status_next = hrl_pkg::ST_SHORT;
                    end
                    else if ({1'b0, record_addr_next} >= limit)
                    begin
                        ended_next        = 1'b1;
                        final_status_next = hrl_pkg::ST_RANGE;
                    end
                    else
                    begin
                        result.write_valid = 1'b1;
                        result.write_addr  = record_addr_next;
                        result.write_data  = beat.byte_value;
                        record_addr_next   = record_addr_next + 16'd1;
                        running_sum_next   = sum_with_byte;
                        bytes_left_next    = bytes_left_next - 8'd1;
                        if (bytes_left_next == 8'd0)
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                end
                default:
                begin
                    // Checksum byte: the whole record must sum to zero.
                    if (sum_with_byte != 8'd0)
                    begin
                        ended_next        = 1'b1;
                        final_status_next = hrl_pkg::ST_SUM;
                    end
                    else if (record_type_next == hrl_pkg::REC_END)
                    begin
                        ended_next        = 1'b1;
                        final_status_next = hrl_pkg::ST_OK;
                    end
                    else if (beat.last_byte)
                    begin
                        ended_next        = 1'b1;
                        final_status_next = hrl_pkg::ST_SHORT;
                    end
                    else
                    begin
                        phase_next       = PH_LEN;
                        running_sum_next = '0;
                    end
                end
            endcase
        end

        result.finished = ended_next;
        result.status   = final_status_next;
    end

    // Parse state advances once per byte handed over by the top level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_LEN;
            record_length_reg <= '0;
            record_addr_reg   <= '0;
            record_type_reg   <= '0;
            bytes_left_reg    <= '0;
            running_sum_reg   <= '0;
            ended_reg         <= 1'b0;
            final_status_reg  <= hrl_pkg::ST_BUSY;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            record_length_reg <= record_length_next;
            record_addr_reg   <= record_addr_next;
            record_type_reg   <= record_type_next;
            bytes_left_reg    <= bytes_left_next;
            running_sum_reg   <= running_sum_next;
            ended_reg         <= ended_next;
            final_status_reg  <= final_status_next;
        end
    end

endmodule

`default_nettype wire
